// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros used by lsf_back.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== design/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and codes for the learning switch forwarder.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int KEY_W = 64;

  typedef enum logic [1:0] {
    DROP_NONE     = 2'd0,
    DROP_FILTERED = 2'd1,
    DROP_HOPPED   = 2'd2,
    DROP_SAMEPORT = 2'd3
  } drop_t;

  // classified word handed from front to back
  typedef struct packed {
    logic             flush;
    logic             filtered;
    logic             bcast;
    logic [2:0]       port;
    logic [KEY_W-1:0] src;
    logic [KEY_W-1:0] dst;
  } job_t;

  localparam int JOB_W = $bits(job_t);

endpackage

// ===== design/learning_switch_forwarder.sv =====
// ----------------------------------------------------------------------------
// learning_switch_forwarder
// Learning bridge address table: learns sources, forwards by destination.
// ----------------------------------------------------------------------------
// Use:
//   in_  : one word per packet or flush request (mode in tuser).
//   out_ : one result word per input word, in order.
//   cfg_ : write port_enable with cfg_wr_en/cfg_wr_data while idle.
// A packet runs up to two sequential table searches (one entry read per cycle
//   from the table memory port); a flush runs one sweep of the table; a
//   filtered word goes straight to the result.
// A two-word queue sits in front of the table sequencer, so new words are
//   taken while a result waits. The result stays in its register until
//   out_tready; the sequencer holds meanwhile.
// Reset clears all valid marks at once and port_enable to zero.
// ----------------------------------------------------------------------------
module learning_switch_forwarder
  import lsf_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int PORT_COUNT    = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: ingress_port[2:0], source_key[66:3], dest_key[130:67],
  //        dest_is_broadcast[131], filter_pass[132], zero fill
  input  logic [135:0] in_tdata,
  // tuser: mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: forward_mask[7:0], drop_reason[9:8], learned[10],
  //        table_full[11], flushed_count[18:12], zero fill
  output logic [23:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);

  logic [7:0] port_enable_r;
  logic       job_valid, job_ready;
  job_t       job;
  logic [7:0] mask;
  drop_t      reason;
  logic       learned, full;
  logic [6:0] flushed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_enable_r <= '0;
    end else if (cfg_wr_en) begin
      port_enable_r <= cfg_wr_data;
    end
  end

  lsf_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready),
    .in_port  (in_tdata[2:0]), .in_mode (in_tuser),
    .in_src   (in_tdata[66:3]), .in_dst (in_tdata[130:67]),
    .in_bcast (in_tdata[131]), .in_pass (in_tdata[132]),
    .job_valid, .job_ready, .job
  );

  lsf_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .PORT_COUNT(PORT_COUNT)) u_back (
    .clk, .rst_n, .port_enable (port_enable_r),
    .job_valid, .job_ready, .job,
    .res_valid (out_tvalid), .res_ready (out_tready),
    .res_mask (mask), .res_reason (reason), .res_learned (learned),
    .res_full (full), .res_flushed (flushed)
  );

  assign out_tdata = {5'd0, flushed, full, learned, reason, mask};

endmodule

// ===== design/lsf_front.sv =====
// ----------------------------------------------------------------------------
// lsf_front
// Accepts input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module lsf_front
  import lsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_port,
  input  logic       in_mode,
  input  logic [KEY_W-1:0] in_src,
  input  logic [KEY_W-1:0] in_dst,
  input  logic       in_bcast,
  input  logic       in_pass,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  job_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  job_t       cls;
  logic       push, pop;

  always_comb begin
    cls.flush    = in_mode;
    cls.filtered = !in_mode && !in_pass;
    cls.bcast    = in_bcast;
    cls.port     = in_port;
    cls.src      = in_src;
    cls.dst      = in_dst;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;
  assign wp_nxt    = wp_r ^ push;
  assign rp_nxt    = rp_r ^ pop;
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/lsf_back.sv =====
// ----------------------------------------------------------------------------
// lsf_back
// Sequencer over the station table: source search, learning, destination
// search and flush sweep, one entry a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lsf_back
  import lsf_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int PORT_COUNT    = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] port_enable,
  input  logic       job_valid,
  output logic       job_ready,
  input  job_t       job,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] res_mask,
  output drop_t      res_reason,
  output logic       res_learned,
  output logic       res_full,
  output logic [6:0] res_flushed
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);
  localparam logic [7:0] LIMIT =
    (PORT_COUNT >= 8) ? 8'hFF : 8'((9'd1 << PORT_COUNT) - 9'd1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRC   = 6'b000010,
    S_DST   = 6'b000100,
    S_FLUSH = 6'b001000,
    S_READ  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [2:0]       port_mem [TABLE_ENTRIES];
  job_t             job_r;
  logic [CW-1:0]    idx_r;
  logic [IW-1:0]    ai;
  logic [KEY_W-1:0] rkey_r;
  logic [2:0]       rport_r;
  logic             rvalid_r;
  logic [IW-1:0]    ridx_r;
  logic             rlast_r;
  logic             hit_r, free_f_r;
  logic [IW-1:0]    free_i_r;
  logic [2:0]       hport_r;
  logic [7:0]       mask_r;
  drop_t            reason_r;
  logic             learned_r, full_r;
  logic [6:0]       flushed_r;
  logic             scanning, match, rd_en, issue;
  logic [KEY_W-1:0] want;

  assign ai        = idx_r[IW-1:0];
  assign job_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_mask  = mask_r;
  assign res_reason = reason_r;
  assign res_learned = learned_r;
  assign res_full    = full_r;
  assign res_flushed = flushed_r;
  assign scanning  = (state_r == S_SRC) || (state_r == S_DST) || (state_r == S_FLUSH);
  assign rd_en     = scanning && !hit_r;
  assign issue     = rd_en && (idx_r <= LAST);
  assign want      = (state_r == S_DST) ? job_r.dst : job_r.src;

  // registered table read, one entry a cycle, and write of a learnt key in S_READ
  always_ff @(posedge clk) begin
    rkey_r  <= key_mem[ai];
    rport_r <= port_mem[ai];
    if (state_r == S_READ && learned_r) begin
      key_mem[free_i_r]  <= job_r.src;
      port_mem[free_i_r] <= job_r.port;
    end
  end

  assign match = rvalid_r && (rkey_r == want);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (job_valid) begin
        if (job.flush) state_nxt = S_FLUSH;
        else if (job.filtered) state_nxt = S_OUT;
        else state_nxt = S_SRC;
      end
      S_SRC, S_DST, S_FLUSH: state_nxt = state_r;
      S_READ:  state_nxt = S_OUT;
      S_OUT:   if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // pipeline: the issue stage reads entry idx into rkey_r/rport_r; the evaluate stage sees the data (rvalid_r/ridx_r)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      rvalid_r <= 1'b0;
      learned_r <= 1'b0;
    end else begin
      rvalid_r <= issue && valid_r[ai];
      rlast_r  <= issue && (idx_r == LAST);
      if (issue) ridx_r <= ai;
      priority case (1'b1)
        state_r == S_IDLE: begin
          if (job_valid) begin
            job_r     <= job;
            idx_r     <= '0;
            hit_r     <= 1'b0;
            free_f_r  <= 1'b0;
            free_i_r  <= '0;
            mask_r    <= '0;
            reason_r  <= job.filtered ? DROP_FILTERED : DROP_NONE;
            learned_r <= 1'b0;
            full_r    <= 1'b0;
            flushed_r <= '0;
          end
          state_r <= state_nxt;
        end
        scanning: begin
          // issue stage
          if (issue) idx_r <= idx_r + CW'(1);
          // evaluate stage
          if (idx_r != '0 && !hit_r) begin
            if (state_r == S_FLUSH) begin
              if (rvalid_r && rport_r == job_r.port) begin
                valid_r[ridx_r] <= 1'b0;
                if (flushed_r != 7'd127) flushed_r <= flushed_r + 7'd1;
              end
            end else begin
              if (state_r == S_SRC && !valid_r[ridx_r] && !free_f_r &&
                  !(rvalid_r)) begin
                free_f_r <= 1'b1;
                free_i_r <= ridx_r;
              end
              if (match) begin
                hit_r   <= 1'b1;
                hport_r <= rport_r;
              end
            end
          end
          if (idx_r > LAST && !rlast_r && (hit_r || !match || state_r == S_FLUSH)) begin
            // scan finished (or stopped on a hit): resolve
            unique case (state_r)
              S_FLUSH: state_r <= S_OUT;
              S_SRC: begin
                if (hit_r) begin
                  if (hport_r != job_r.port) begin
                    reason_r <= DROP_HOPPED;
                    state_r  <= S_OUT;
                  end else state_r <= S_READ;
                end else if (free_f_r) begin
                  valid_r[free_i_r] <= 1'b1;
                  learned_r <= 1'b1;
                  state_r   <= S_READ;
                end else begin
                  full_r  <= 1'b1;
                  state_r <= S_READ;
                end
              end
              default: begin
                if (hit_r) begin
                  if (hport_r != job_r.port) mask_r <= 8'(9'd1 << hport_r);
                  else reason_r <= DROP_SAMEPORT;
                end else begin
                  mask_r <= port_enable & ~8'(9'd1 << job_r.port) & LIMIT;
                end
                state_r <= S_OUT;
              end
            endcase
          end else if (hit_r && state_r != S_FLUSH) begin
            idx_r <= LAST + CW'(1);
          end
        end
        state_r == S_READ: begin
          // write of learnt key lands this cycle; start destination scan or finish a broadcast
          idx_r <= '0;
          hit_r <= 1'b0;
          if (job_r.bcast) begin
            mask_r  <= port_enable & ~8'(9'd1 << job_r.port) & LIMIT;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DST;
          end
        end
        default: state_r <= state_nxt;
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, job_ready |-> res_valid == 1'b0)
  `ASSERT_IMPL(a_out_hold, clk, rst_n, (res_valid && !res_ready) |=> res_valid)
  `ASSERT_NEVER(a_learn_drop, clk, rst_n, res_valid && res_learned && res_full)

endmodule
